// ----- rtl/sact_pkg.sv -----
package sact_pkg;

  // Widths of the fixed channel fields.
  localparam int unsigned AddrW    = 32;
  localparam int unsigned DataW    = 32;
  localparam int unsigned WayOutW  = 2;
  localparam int unsigned SetOutW  = 6;
  localparam int unsigned WordOffW = 2;

  // Access types on the request channel.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Kinds of response.
  localparam logic KIND_DEMAND   = 1'b0;
  localparam logic KIND_PREFETCH = 1'b1;

  // One response as it sits in the holding and output registers.
  typedef struct packed {
    logic                kind;
    logic                hit;
    logic [WayOutW-1:0]  way;
    logic [SetOutW-1:0]  set_index;
    logic [WordOffW-1:0] word_offset;
    logic                writeback;
    logic [AddrW-1:0]    writeback_block_addr;
    logic                fill;
    logic [AddrW-1:0]    fill_block_addr;
    logic                write_through;
    logic [DataW-1:0]    through_data;
    logic                last;
  } sact_rsp_t;

  // Status of one set lookup.
  typedef struct packed {
    logic hit;
    logic evict_dirty;
  } sact_stat_t;

endpackage

// ----- rtl/sact_req_if.sv -----
interface sact_req_if;
  import sact_pkg::*;

  logic             valid;
  logic             ready;
  logic             req_type;
  logic [AddrW-1:0] addr;
  logic [DataW-1:0] write_data;

  modport source (output valid, req_type, addr, write_data, input ready);
  modport sink   (input valid, req_type, addr, write_data, output ready);
endinterface

// ----- rtl/sact_rsp_if.sv -----
interface sact_rsp_if;
  import sact_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic                hit;
  logic [WayOutW-1:0]  way;
  logic [SetOutW-1:0]  set_index;
  logic [WordOffW-1:0] word_offset;
  logic                writeback;
  logic [AddrW-1:0]    writeback_block_addr;
  logic                fill;
  logic [AddrW-1:0]    fill_block_addr;
  logic                write_through;
  logic [DataW-1:0]    through_data;
  logic                last;

  modport source (
    output valid, kind, hit, way, set_index, word_offset, writeback, writeback_block_addr,
           fill, fill_block_addr, write_through, through_data, last,
    input  ready
  );
  modport sink (
    input  valid, kind, hit, way, set_index, word_offset, writeback, writeback_block_addr,
           fill, fill_block_addr, write_through, through_data, last,
    output ready
  );
endinterface

// ----- rtl/sact_lookup.sv -----
module sact_lookup #(
  parameter int unsigned WAYS  = 4,
  parameter int unsigned TAG_W = 22,
  parameter int unsigned WAY_W = 2
) (
  input  logic                     valid_i [WAYS],
  input  logic                     dirty_i [WAYS],
  input  logic [WAY_W-1:0]         rank_i  [WAYS],
  input  logic [TAG_W-1:0]         tag_i   [WAYS],
  input  logic [TAG_W-1:0]         look_tag_i,
  input  logic                     set_dirty_i,
  output sact_pkg::sact_stat_t     stat_o,
  output logic [WAY_W-1:0]         way_o,
  output logic [TAG_W-1:0]         victim_tag_o,
  output logic                     valid_o [WAYS],
  output logic                     dirty_o [WAYS],
  output logic [WAY_W-1:0]         rank_o  [WAYS],
  output logic [TAG_W-1:0]         tag_o   [WAYS]
);
  import sact_pkg::*;

  localparam logic [WAY_W-1:0] RankMax = WAY_W'(WAYS - 1);

  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] vict_way;
  logic [WAY_W-1:0] sel_way;
  logic [WAY_W-1:0] sel_rank;

  // Match and victim search; the lowest matching way wins, and the victim
  // is the one way that holds the oldest rank.
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    vict_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid_i[w] && (tag_i[w] == look_tag_i)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (rank_i[w] == RankMax) begin
        vict_way = WAY_W'(w);
      end
    end
  end

  assign sel_way  = hit ? hit_way : vict_way;
  assign sel_rank = rank_i[sel_way];

  // Updated entries: the selected way becomes most recent, and every way
  // that was more recent than it ages by one.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == sel_way) begin
        valid_o[w] = 1'b1;
        dirty_o[w] = hit ? (dirty_i[w] | set_dirty_i) : set_dirty_i;
        tag_o[w]   = hit ? tag_i[w] : look_tag_i;
        rank_o[w]  = '0;
      end else begin
        valid_o[w] = valid_i[w];
        dirty_o[w] = dirty_i[w];
        tag_o[w]   = tag_i[w];
        rank_o[w]  = (rank_i[w] < sel_rank) ? rank_i[w] + 1'b1 : rank_i[w];
      end
    end
  end

  assign stat_o.hit         = hit;
  assign stat_o.evict_dirty = !hit && valid_i[vict_way] && dirty_i[vict_way];
  assign way_o              = sel_way;
  assign victim_tag_o       = tag_i[vict_way];

endmodule

// ----- rtl/set_assoc_cache_tag_controller.sv -----
// Channel  | Direction | Carries
// ---------+-----------+-----------------------------------------------------------
// req_i    | in        | one access request: req_type, addr, write_data
// rsp_o    | out       | demand response or prefetch command, last marks the end
//
// A read hit or any write accepts the request and reads the set row, then looks it up
// and writes the row back. A read miss adds one prefetch lookup for each of the
// PREFETCH_DEPTH following blocks, and enters the flush state when the final prefetch
// lookup emits a command. The tag memory reads one row and writes one row per cycle.
// After reset the block clears every tag memory row and takes no request. A full
// response register stalls only the flush state and lookups that hand it a response.
module set_assoc_cache_tag_controller #(
  parameter int unsigned WAYS           = 4,
  parameter int unsigned SETS           = 64,
  parameter int unsigned BLOCK_BYTES    = 16,
  parameter int unsigned ADDR_BITS      = 32,
  parameter int unsigned PREFETCH_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sact_req_if.sink    req_i,
  sact_rsp_if.source  rsp_o
);
  import sact_pkg::*;

  // Address split: tag | set | block offset.
  localparam int unsigned OB      = $clog2(BLOCK_BYTES);
  localparam int unsigned IB      = $clog2(SETS);
  localparam int unsigned SET_W   = (IB > 0) ? IB : 1;
  localparam int          TAG_RAW = int'(ADDR_BITS) - int'(OB) - int'(IB);
  localparam int unsigned TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ENT_W   = TAG_W + WAY_W + 2;
  localparam int unsigned ROW_W   = WAYS * ENT_W;
  localparam int unsigned PF_W    = (PREFETCH_DEPTH > 0) ? $clog2(PREFETCH_DEPTH + 1) : 1;

  localparam logic [SET_W-1:0]     SetMask  = SET_W'(SETS - 1);
  localparam logic [SET_W-1:0]     SetLast  = SET_W'(SETS - 1);
  localparam logic [ADDR_BITS-1:0] BlkMask  = ADDR_BITS'(BLOCK_BYTES - 1);
  localparam logic [ADDR_BITS-1:0] BlkStep  = ADDR_BITS'(BLOCK_BYTES);
  localparam logic [WordOffW-1:0]  WordMask = WordOffW'((BLOCK_BYTES / 4 - 1) & 3);
  localparam logic [PF_W-1:0]      PfLast   = PF_W'(PREFETCH_DEPTH);
  localparam logic                 NoPf     = (PREFETCH_DEPTH == 0);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FLUSH
  } state_e;

  function automatic logic [SET_W-1:0] set_of(input logic [ADDR_BITS-1:0] a);
    return SET_W'(a >> OB) & SetMask;
  endfunction

  function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_BITS-1:0] a);
    return TAG_W'(a >> (OB + IB));
  endfunction

  // Tag memory: one row per set, each row holds {valid, dirty, rank, tag} per way.
  logic [ROW_W-1:0] mem_q [SETS];
  logic [ROW_W-1:0] mem_rdata_q;
  logic             mem_we;
  logic [SET_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic             mem_re;
  logic [SET_W-1:0] mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  // Control and payload registers.
  state_e                state_q, state_d;
  logic [SET_W-1:0]      clr_cnt_q, clr_cnt_d;
  logic [PF_W-1:0]       pf_cnt_q, pf_cnt_d;
  logic [ADDR_BITS-1:0]  cur_addr_q, cur_addr_d;
  logic                  is_write_q, is_write_d;
  logic [DataW-1:0]      wdata_q, wdata_d;
  logic                  fwd_q, fwd_d;
  logic [ROW_W-1:0]      fwd_row_q, fwd_row_d;
  logic                  pend_valid_q, pend_valid_d;
  sact_rsp_t             pend_q, pend_d;
  logic                  out_valid_q, out_valid_d;
  sact_rsp_t             out_q, out_d;

  // The row under lookup: the memory read, or the row written in the cycle
  // the read was issued when both name the same set.
  logic [ROW_W-1:0] row_cur;
  logic [ROW_W-1:0] row_new;
  logic [ROW_W-1:0] clr_row;
  logic             ent_valid [WAYS];
  logic             ent_dirty [WAYS];
  logic [WAY_W-1:0] ent_rank  [WAYS];
  logic [TAG_W-1:0] ent_tag   [WAYS];
  logic             new_valid [WAYS];
  logic             new_dirty [WAYS];
  logic [WAY_W-1:0] new_rank  [WAYS];
  logic [TAG_W-1:0] new_tag   [WAYS];
  logic [WAYS-1:0]  oldest_mask;

  assign row_cur = fwd_q ? fwd_row_q : mem_rdata_q;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      ent_valid[w] = row_cur[w*ENT_W + ENT_W - 1];
      ent_dirty[w] = row_cur[w*ENT_W + ENT_W - 2];
      ent_rank[w]  = row_cur[w*ENT_W + TAG_W +: WAY_W];
      ent_tag[w]   = row_cur[w*ENT_W +: TAG_W];
      row_new[w*ENT_W +: ENT_W] = {new_valid[w], new_dirty[w], new_rank[w], new_tag[w]};
      clr_row[w*ENT_W +: ENT_W] = {1'b0, 1'b0, WAY_W'(w), TAG_W'(0)};
      oldest_mask[w] = (new_rank[w] == WAY_W'(WAYS - 1));
    end
  end

  logic                 is_demand;
  logic [SET_W-1:0]     cur_set;
  logic [TAG_W-1:0]     cur_tag;
  sact_stat_t           stat;
  logic [WAY_W-1:0]     sel_way;
  logic [TAG_W-1:0]     victim_tag;

  assign is_demand = (pf_cnt_q == '0);
  assign cur_set   = set_of(cur_addr_q);
  assign cur_tag   = tag_of(cur_addr_q);

  sact_lookup #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W),
    .WAY_W (WAY_W)
  ) u_lookup (
    .valid_i      (ent_valid),
    .dirty_i      (ent_dirty),
    .rank_i       (ent_rank),
    .tag_i        (ent_tag),
    .look_tag_i   (cur_tag),
    .set_dirty_i  (is_demand && is_write_q),
    .stat_o       (stat),
    .way_o        (sel_way),
    .victim_tag_o (victim_tag),
    .valid_o      (new_valid),
    .dirty_o      (new_dirty),
    .rank_o       (new_rank),
    .tag_o        (new_tag)
  );

  // Response built from the current lookup. Prefetch lookups that hit emit nothing.
  sact_rsp_t            rsp_cur;
  logic                 emit;
  logic                 last_lkp;
  logic [ADDR_BITS-1:0] wb_addr;
  logic [ADDR_BITS-1:0] ahead_addr;

  assign wb_addr    = (ADDR_BITS'(victim_tag) << (OB + IB)) | (ADDR_BITS'(cur_set) << OB);
  assign ahead_addr = cur_addr_q + BlkStep;
  assign emit       = is_demand || !stat.hit;
  assign last_lkp   = is_demand ? (stat.hit || is_write_q || NoPf) : (pf_cnt_q == PfLast);

  always_comb begin
    rsp_cur                      = '0;
    rsp_cur.kind                 = is_demand ? KIND_DEMAND : KIND_PREFETCH;
    rsp_cur.hit                  = is_demand && stat.hit;
    rsp_cur.way                  = WayOutW'(sel_way);
    rsp_cur.set_index            = SetOutW'(cur_set);
    rsp_cur.fill                 = !stat.hit;
    rsp_cur.fill_block_addr      = stat.hit ? '0 : AddrW'(cur_addr_q & ~BlkMask);
    if (is_demand) begin
      rsp_cur.word_offset          = WordOffW'(cur_addr_q >> 2) & WordMask;
      rsp_cur.writeback            = stat.evict_dirty;
      rsp_cur.writeback_block_addr = stat.evict_dirty ? AddrW'(wb_addr) : '0;
      rsp_cur.write_through        = is_write_q;
      rsp_cur.through_data         = is_write_q ? wdata_q : '0;
    end
  end

  // The last response of an access is known only after its final lookup, so
  // each response waits in a holding register until the next one shows up or
  // the access ends.
  logic      slot_free;
  logic      push;
  sact_rsp_t push_rsp;
  logic      go;

  assign slot_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    push     = 1'b0;
    push_rsp = pend_q;
    if (state_q == ST_LOOKUP) begin
      if (emit && pend_valid_q) begin
        push          = 1'b1;
        push_rsp      = pend_q;
        push_rsp.last = 1'b0;
      end else if (emit && last_lkp) begin
        push          = 1'b1;
        push_rsp      = rsp_cur;
        push_rsp.last = 1'b1;
      end else if (last_lkp) begin
        push          = 1'b1;
        push_rsp      = pend_q;
        push_rsp.last = 1'b1;
      end
    end else if (state_q == ST_FLUSH) begin
      push          = 1'b1;
      push_rsp      = pend_q;
      push_rsp.last = 1'b1;
    end
  end

  assign go = !push || slot_free;

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    pf_cnt_d     = pf_cnt_q;
    cur_addr_d   = cur_addr_q;
    is_write_d   = is_write_q;
    wdata_d      = wdata_q;
    fwd_d        = fwd_q;
    fwd_row_d    = fwd_row_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    mem_we       = 1'b0;
    mem_waddr    = cur_set;
    mem_wdata    = row_new;
    mem_re       = 1'b0;
    mem_raddr    = cur_set;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = clr_row;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == SetLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          mem_re     = 1'b1;
          mem_raddr  = set_of(req_i.addr[ADDR_BITS-1:0]);
          cur_addr_d = req_i.addr[ADDR_BITS-1:0];
          is_write_d = (req_i.req_type == REQ_WRITE);
          wdata_d    = req_i.write_data;
          pf_cnt_d   = '0;
          fwd_d      = 1'b0;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (go) begin
          mem_we = 1'b1;
          if (last_lkp) begin
            if (emit && pend_valid_q) begin
              pend_d  = rsp_cur;
              state_d = ST_FLUSH;
            end else begin
              pend_valid_d = 1'b0;
              state_d      = ST_IDLE;
            end
          end else begin
            if (emit) begin
              pend_valid_d = 1'b1;
              pend_d       = rsp_cur;
            end
            // Read the next block's set in the same cycle as this write-back.
            mem_re     = 1'b1;
            mem_raddr  = set_of(ahead_addr);
            fwd_d      = (set_of(ahead_addr) == cur_set);
            fwd_row_d  = row_new;
            cur_addr_d = ahead_addr;
            pf_cnt_d   = pf_cnt_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (push && slot_free) begin
      out_valid_d = 1'b1;
      out_d       = push_rsp;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      pf_cnt_q     <= '0;
      cur_addr_q   <= '0;
      is_write_q   <= 1'b0;
      wdata_q      <= '0;
      fwd_q        <= 1'b0;
      fwd_row_q    <= '0;
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      pf_cnt_q     <= pf_cnt_d;
      cur_addr_q   <= cur_addr_d;
      is_write_q   <= is_write_d;
      wdata_q      <= wdata_d;
      fwd_q        <= fwd_d;
      fwd_row_q    <= fwd_row_d;
      pend_valid_q <= pend_valid_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  // Port drive.
  assign req_i.ready                = (state_q == ST_IDLE);
  assign rsp_o.valid                = out_valid_q;
  assign rsp_o.kind                 = out_q.kind;
  assign rsp_o.hit                  = out_q.hit;
  assign rsp_o.way                  = out_q.way;
  assign rsp_o.set_index            = out_q.set_index;
  assign rsp_o.word_offset          = out_q.word_offset;
  assign rsp_o.writeback            = out_q.writeback;
  assign rsp_o.writeback_block_addr = out_q.writeback_block_addr;
  assign rsp_o.fill                 = out_q.fill;
  assign rsp_o.fill_block_addr      = out_q.fill_block_addr;
  assign rsp_o.write_through        = out_q.write_through;
  assign rsp_o.through_data         = out_q.through_data;
  assign rsp_o.last                 = out_q.last;

  // A new request is only taken once every response of the previous one has left
  // the holding register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !pend_valid_q)
    else $error("request taken while a response is still held");

  // The flush state exists only to release a held response.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> pend_valid_q)
    else $error("flush without a held response");

  // Every row written back by a lookup keeps exactly one oldest way.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP && go) |-> $onehot(oldest_mask))
    else $error("LRU ranks of the written row are not a permutation");

  // Forwarding is armed exactly when a read collides with the row being written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP && mem_we && mem_re) |=>
      (fwd_q == ($past(mem_waddr) == $past(mem_raddr))))
    else $error("forwarding flag disagrees with the read and write sets");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sact_pkg::*;

  // Geometry of the cache under test, matching the default parameters of the block.
  localparam int unsigned NumWays     = 4;
  localparam int unsigned NumSets     = 64;
  localparam int unsigned BlockBytes  = 16;
  localparam int unsigned PfDepth     = 4;
  localparam int unsigned OffW        = 4;   // byte offset bits within a block
  localparam int unsigned SetW        = 6;   // set index bits
  localparam int unsigned TagW        = AddrW - SetW - OffW;
  localparam int unsigned RandomItems = 47;  // per idling phase, four phases
  localparam int unsigned TailCycles  = 20;  // longest read miss plus margin
  localparam int unsigned CycleLimit  = 400000;

  // The scoreboard keeps its own copy of the tag, valid, dirty and LRU state.
  // Every accepted request is run through that copy at once, and the responses
  // it must cause are queued in order. Each response seen on the output is then
  // compared with the oldest queued one.
  class access_scoreboard;
    logic [TagW-1:0] line_tag   [NumSets][NumWays];
    bit              line_valid [NumSets][NumWays];
    bit              line_dirty [NumSets][NumWays];
    bit [1:0]        lru_rank   [NumSets][NumWays];
    sact_rsp_t       pending_rsp[$];
    int unsigned     mismatches;
    int unsigned     rsp_count;

    function new();
      for (int s = 0; s < NumSets; s++) begin
        for (int w = 0; w < NumWays; w++) begin
          line_tag[s][w]   = '0;
          line_valid[s][w] = 1'b0;
          line_dirty[s][w] = 1'b0;
          lru_rank[s][w]   = 2'(w);
        end
      end
      mismatches = 0;
      rsp_count  = 0;
    endfunction

    // Make the way the most recent one; only ways that were more recent age.
    function void touch(logic [SetW-1:0] s, int w);
      bit [1:0] r;
      r = lru_rank[s][w];
      for (int i = 0; i < NumWays; i++) begin
        if (lru_rank[s][i] < r) lru_rank[s][i]++;
      end
      lru_rank[s][w] = 2'd0;
    endfunction

    function int victim(logic [SetW-1:0] s);
      int best;
      best = 0;
      for (int i = 1; i < NumWays; i++) begin
        if (lru_rank[s][i] > lru_rank[s][best]) best = i;
      end
      return best;
    endfunction

    // Returns NumWays when no valid way of the set holds the tag.
    function int lookup(logic [SetW-1:0] s, logic [TagW-1:0] t);
      for (int i = 0; i < NumWays; i++) begin
        if (line_valid[s][i] && line_tag[s][i] == t) return i;
      end
      return NumWays;
    endfunction

    function void install(logic [SetW-1:0] s, int w, logic [TagW-1:0] t, bit dirty);
      line_tag[s][w]   = t;
      line_valid[s][w] = 1'b1;
      line_dirty[s][w] = dirty;
      touch(s, w);
    endfunction

    function void predict_access(logic rtype, logic [AddrW-1:0] a, logic [DataW-1:0] wdata);
      sact_rsp_t        rsp;
      sact_rsp_t        burst[$];
      logic [SetW-1:0]  s;
      logic [TagW-1:0]  t;
      logic [AddrW-1:0] na;
      bit               is_write;
      bit               hit;
      int               w;
      s        = a[OffW +: SetW];
      t        = a[AddrW-1 -: TagW];
      is_write = (rtype == REQ_WRITE);
      w        = lookup(s, t);
      hit      = (w < NumWays);
      rsp      = '0;
      rsp.kind        = KIND_DEMAND;
      rsp.hit         = hit;
      rsp.set_index   = s;
      rsp.word_offset = a[OffW-1:2];
      if (hit) begin
        touch(s, w);
        if (is_write) line_dirty[s][w] = 1'b1;
      end else begin
        w = victim(s);
        if (line_valid[s][w] && line_dirty[s][w]) begin
          rsp.writeback            = 1'b1;
          rsp.writeback_block_addr = {line_tag[s][w], s, {OffW{1'b0}}};
        end
        rsp.fill            = 1'b1;
        rsp.fill_block_addr = {a[AddrW-1:OffW], {OffW{1'b0}}};
        install(s, w, t, is_write);
      end
      rsp.way           = w[WayOutW-1:0];
      rsp.write_through = is_write;
      rsp.through_data  = is_write ? wdata : '0;
      rsp.last          = 1'b1;
      burst.push_back(rsp);
      // Only a read miss looks ahead. Prefetch hits just refresh LRU, and a
      // dirty line pushed out by a prefetch is dropped without a write-back.
      if (!hit && !is_write) begin
        for (int i = 1; i <= PfDepth; i++) begin
          na = a + AddrW'(i * BlockBytes);
          s  = na[OffW +: SetW];
          t  = na[AddrW-1 -: TagW];
          w  = lookup(s, t);
          if (w < NumWays) begin
            touch(s, w);
          end else begin
            w = victim(s);
            install(s, w, t, 1'b0);
            rsp                 = '0;
            rsp.kind            = KIND_PREFETCH;
            rsp.way             = w[WayOutW-1:0];
            rsp.set_index       = s;
            rsp.fill            = 1'b1;
            rsp.fill_block_addr = {na[AddrW-1:OffW], {OffW{1'b0}}};
            rsp.last            = 1'b1;
            burst[burst.size()-1].last = 1'b0;
            burst.push_back(rsp);
          end
        end
      end
      foreach (burst[k]) pending_rsp.push_back(burst[k]);
    endfunction

    task report(string msg);
      mismatches++;
      $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report($sformatf("response %0d field %s got 0x%0h expected 0x%0h",
                         rsp_count, name, got, want));
      end
    endtask

    task check_rsp(sact_rsp_t got);
      sact_rsp_t want;
      if (pending_rsp.size() == 0) begin
        report($sformatf("response %0d arrived with none outstanding", rsp_count));
      end else begin
        want = pending_rsp.pop_front();
        compare_field("kind", 32'(got.kind), 32'(want.kind));
        compare_field("hit", 32'(got.hit), 32'(want.hit));
        compare_field("way", 32'(got.way), 32'(want.way));
        compare_field("set_index", 32'(got.set_index), 32'(want.set_index));
        compare_field("word_offset", 32'(got.word_offset), 32'(want.word_offset));
        compare_field("writeback", 32'(got.writeback), 32'(want.writeback));
        compare_field("writeback_block_addr", got.writeback_block_addr,
                      want.writeback_block_addr);
        compare_field("fill", 32'(got.fill), 32'(want.fill));
        compare_field("fill_block_addr", got.fill_block_addr, want.fill_block_addr);
        compare_field("write_through", 32'(got.write_through), 32'(want.write_through));
        compare_field("through_data", got.through_data, want.through_data);
        compare_field("last", 32'(got.last), 32'(want.last));
      end
      rsp_count++;
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned cycle_count;

  access_scoreboard sb = new();

  sact_req_if req_bus ();
  sact_rsp_if rsp_bus ();

  set_assoc_cache_tag_controller dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog. The slowest correct run is far below this limit, even with every
  // response stalled and the clearing pass after reset counted in.
  initial begin
    for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  // The response side stalls at random on every cycle. The stall rate is set by
  // the phase in progress, so back-pressure lands on every step of a read miss.
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_bus.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Every response taken at a rising edge goes straight to the scoreboard.
  always @(posedge clk_i) begin : rsp_monitor
    sact_rsp_t got;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      got.kind                 = rsp_bus.kind;
      got.hit                  = rsp_bus.hit;
      got.way                  = rsp_bus.way;
      got.set_index            = rsp_bus.set_index;
      got.word_offset          = rsp_bus.word_offset;
      got.writeback            = rsp_bus.writeback;
      got.writeback_block_addr = rsp_bus.writeback_block_addr;
      got.fill                 = rsp_bus.fill;
      got.fill_block_addr      = rsp_bus.fill_block_addr;
      got.write_through        = rsp_bus.write_through;
      got.through_data         = rsp_bus.through_data;
      got.last                 = rsp_bus.last;
      sb.check_rsp(got);
    end
  end

  // Presents one request. It is called right after a rising edge, and it drives
  // only at falling edges. Valid stays high straight into the next request when
  // no idle cycle is drawn, so back-to-back requests keep the channel busy.
  task automatic send_request(input logic rtype, input logic [AddrW-1:0] a,
                              input logic [DataW-1:0] d);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      req_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid      = 1'b1;
    req_bus.req_type   = rtype;
    req_bus.addr       = a;
    req_bus.write_data = d;
    do @(posedge clk_i); while (!req_bus.ready);
    sb.predict_access(rtype, a, d);
  endtask

  // Holds the request side quiet until every queued response has come back.
  task automatic drain_responses();
    @(negedge clk_i);
    req_bus.valid = 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [AddrW-1:0] block_addr(logic [TagW-1:0] t, logic [SetW-1:0] s,
                                                   logic [OffW-1:0] off);
    return {t, s, off};
  endfunction

  // Random traffic. Most addresses come from a handful of tags over sixteen sets,
  // half of them at the top of the index range, so hits, dirty evictions and
  // prefetches that cross into the next tag are common. A fifth of the addresses
  // are drawn over the whole space so that every address bit moves.
  task automatic run_phase(int unsigned idle, int unsigned stall, bit pause_midway);
    logic [TagW-1:0]  hot_tag;
    logic [TagW-1:0]  t;
    logic [SetW-1:0]  s;
    logic [AddrW-1:0] a;
    logic             rtype;
    idle_pct  = idle;
    stall_pct = stall;
    hot_tag   = TagW'($urandom);
    for (int n = 0; n < RandomItems; n++) begin
      if (pause_midway && n == RandomItems / 2) drain_responses();
      rtype = ($urandom_range(99) < 40) ? REQ_WRITE : REQ_READ;
      if ($urandom_range(99) < 20) begin
        a = $urandom;
      end else begin
        case ($urandom_range(5))
          0:       t = '0;
          1:       t = TagW'(1);
          2:       t = TagW'(2);
          3:       t = TagW'(3);
          4:       t = '1;
          default: t = hot_tag;
        endcase
        s = $urandom_range(1) ? SetW'($urandom_range(7)) : SetW'(56 + $urandom_range(7));
        a = block_addr(t, s, OffW'($urandom_range(15)));
      end
      send_request(rtype, a, $urandom);
    end
    drain_responses();
  endtask

  initial begin
    req_bus.valid      = 1'b0;
    req_bus.req_type   = REQ_READ;
    req_bus.addr       = '0;
    req_bus.write_data = '0;
    idle_pct           = 0;
    stall_pct          = 0;
    rst_ni             = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, with no idling on either side.
    // A read of address zero right after reset must miss, since every line is
    // invalid even though its tag reads as zero. It prefetches sets one to four.
    send_request(REQ_READ, 32'h0000_0000, 32'h0);
    send_request(REQ_READ, 32'h0000_0004, 32'hFFFF_FFFF);
    // A write hit marks the line dirty and writes through.
    send_request(REQ_WRITE, 32'h0000_000C, 32'hFFFF_FFFF);
    // Reading a prefetched block hits.
    send_request(REQ_READ, block_addr(TagW'(0), SetW'(1), OffW'(8)), 32'h0);
    // Three more write misses fill set zero. The fourth pushes out the dirty
    // line at address zero, which must be written back.
    send_request(REQ_WRITE, block_addr(TagW'(1), SetW'(0), OffW'(0)), 32'h1234_5678);
    send_request(REQ_WRITE, block_addr(TagW'(2), SetW'(0), OffW'(4)), 32'h8765_4321);
    send_request(REQ_WRITE, block_addr(TagW'(3), SetW'(0), OffW'(8)), 32'hDEAD_BEEF);
    send_request(REQ_WRITE, block_addr(TagW'(4), SetW'(0), OffW'(12)), 32'h0000_0000);
    // Fill set five with dirty lines, then let a read miss in set four prefetch
    // into it: the dirty victim is dropped without a write-back.
    send_request(REQ_WRITE, block_addr(TagW'(5), SetW'(5), OffW'(0)), 32'hA5A5_A5A5);
    send_request(REQ_WRITE, block_addr(TagW'(6), SetW'(5), OffW'(0)), 32'h5A5A_5A5A);
    send_request(REQ_WRITE, block_addr(TagW'(7), SetW'(5), OffW'(0)), 32'h0F0F_0F0F);
    send_request(REQ_WRITE, block_addr(TagW'(8), SetW'(5), OffW'(0)), 32'hF0F0_F0F0);
    send_request(REQ_READ, block_addr(TagW'(9), SetW'(4), OffW'(0)), 32'h0);
    send_request(REQ_READ, block_addr(TagW'(9), SetW'(4), OffW'(4)), 32'h0);
    // This miss finds all four following blocks present: no prefetch command,
    // the demand response carries the last flag.
    send_request(REQ_READ, block_addr(TagW'(9), SetW'(3), OffW'(0)), 32'h0);
    // The top block of the address space: prefetch addresses wrap to zero.
    send_request(REQ_READ, 32'hFFFF_FFF0, 32'h0);
    send_request(REQ_WRITE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(REQ_READ, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
    send_request(REQ_READ, 32'hAAAA_AAAA, 32'h0);
    send_request(REQ_WRITE, 32'h5555_5555, 32'h5A5A_5A5A);
    send_request(REQ_WRITE, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
    drain_responses();

    // Random part over four idling profiles. The sender also holds off once
    // in the middle of a phase until every queued response has arrived.
    run_phase(0, 0, 1'b0);
    run_phase(86, 0, 1'b1);
    run_phase(0, 86, 1'b0);
    run_phase(16, 16, 1'b0);

    // All queues are empty here; give the block time to show any stray response.
    repeat (TailCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
